// ===== sv/srbs_pkg.sv =====
// ----------------------------------------------------------------------------
// srbs_pkg: shared constants for the switchless ROM bank selector
// Widths of the bank and tick timer, stream data widths, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package srbs_pkg;

    localparam int BANK_BITS   = 2;
    localparam int TIMER_WIDTH = 8;
    localparam int TICKS_WIDTH = 8;
    localparam int CMP_WIDTH   = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    localparam int IN_BITS    = 2;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = BANK_BITS + 4;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TICKS_WIDTH-1:0] HOLD_TICKS_RESET    = TICKS_WIDTH'(15);
    localparam logic [TICKS_WIDTH-1:0] RELEASE_TICKS_RESET = TICKS_WIDTH'(30);
    localparam logic [BANK_BITS-1:0]   START_BANK_RESET    = '0;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RED_INVERTED  = 2'd0,
        REG_START_BANK    = 2'd1,
        REG_HOLD_TICKS    = 2'd2,
        REG_RELEASE_TICKS = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_IDLE   = 1'b0,
        MODE_SELECT = 1'b1
    } mode_t;

endpackage

`default_nettype wire

// ===== sv/switchless_rom_bank_selector_top.sv =====
// ----------------------------------------------------------------------------
// switchless_rom_bank_selector_top
// Polls two active-low buttons once per item and steps a ROM bank selector.
// ----------------------------------------------------------------------------
// Each result is registered in the output stage that drives m_tvalid.
// Throughput: one item per cycle unless the skid entry is full; the state update
// is a single compare and increment between the accepted item and the result register.
// A two-entry output stage lets input continue while one result is stalled.
// Reset (aresetn low at a clock edge) restores register defaults, idle mode
// and start bank 0, and empties the output stage.
`default_nettype none

module switchless_rom_bank_selector_top
    import srbs_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,

    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: restore key level, reset line level.
    input  wire logic [IN_TDATA_W-1:0]      s_tdata,

    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // Fields from bit 0: bank, led, reset_request, save_request, select_mode.
    output logic [OUT_TDATA_W-1:0]          m_tdata
);

    logic                   red_inverted_reg;
    logic [TICKS_WIDTH-1:0] hold_ticks_reg;
    logic [TICKS_WIDTH-1:0] release_ticks_reg;

    mode_t                  mode_reg, mode_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   armed_reg, armed_next;
    logic                   skip_reg, skip_next;
    logic [BANK_BITS-1:0]   bank_reg, bank_next;
    logic [BANK_BITS-1:0]   saved_reg, saved_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [OUT_TDATA_W-1:0] skid_data_reg, skid_data_next;

    logic                   accept;
    logic                   restore_up;
    logic                   reset_up;
    logic                   both_up;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] idle_timer;
    logic                   led;
    logic                   rst_req;
    logic                   save_req;
    logic [OUT_TDATA_W-1:0] result;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign restore_up = s_tdata[0];
    assign reset_up   = s_tdata[1];
    assign both_up    = restore_up && reset_up;
    assign timer_inc  = timer_reg + TIMER_WIDTH'(1);
    assign idle_timer = restore_up ? '0 : timer_inc;

    // LED uses the bank and timer as they stood before this tick.
    assign led = ((bank_reg != '0) && red_inverted_reg) ^ !timer_reg[1];

    always_comb begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        armed_next = armed_reg;
        skip_next  = skip_reg;
        bank_next  = bank_reg;
        saved_next = saved_reg;
        rst_req    = 1'b0;
        save_req   = 1'b0;

        unique case (mode_reg)
            MODE_IDLE: begin
                timer_next = idle_timer;
                if ((CMP_WIDTH'(idle_timer) > CMP_WIDTH'(hold_ticks_reg)) || !reset_up) begin
                    mode_next  = MODE_SELECT;
                    armed_next = 1'b0;
                    timer_next = '0;
                    skip_next  = !reset_up;
                end
            end
            MODE_SELECT: begin
                priority if (!armed_reg && both_up) begin
                    armed_next = 1'b1;
                end else if (armed_reg && !both_up) begin
                    // A press after arming steps the bank and cancels the skip.
                    armed_next = 1'b0;
                    skip_next  = 1'b0;
                    bank_next  = bank_reg + BANK_BITS'(1);
                end else if (both_up) begin
                    timer_next = timer_inc;
                    if (CMP_WIDTH'(timer_inc) > CMP_WIDTH'(release_ticks_reg)) begin
                        armed_next = 1'b1;
                        rst_req    = !skip_reg;
                        if (bank_reg != saved_reg) begin
                            save_req   = 1'b1;
                            saved_next = bank_reg;
                        end
                        timer_next = '0;
                        mode_next  = MODE_IDLE;
                    end
                end else begin
                    timer_next = '0;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    assign result = OUT_TDATA_W'({mode_next == MODE_SELECT, save_req, rst_req, led,
                                  bank_next});

    // Output stage: a main register plus one skid entry behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        priority if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_data_next = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (accept) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
        end else begin
            if (accept) begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_inverted_reg  <= 1'b0;
            hold_ticks_reg    <= HOLD_TICKS_RESET;
            release_ticks_reg <= RELEASE_TICKS_RESET;
            mode_reg          <= MODE_IDLE;
            timer_reg         <= '0;
            armed_reg         <= 1'b0;
            skip_reg          <= 1'b0;
            bank_reg          <= START_BANK_RESET;
            saved_reg         <= START_BANK_RESET;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (accept) begin
                mode_reg  <= mode_next;
                timer_reg <= timer_next;
                armed_reg <= armed_next;
                skip_reg  <= skip_next;
                bank_reg  <= bank_next;
                saved_reg <= saved_next;
            end
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RED_INVERTED:  red_inverted_reg <= cfg_data[0];
                    REG_START_BANK: begin
                        bank_reg  <= cfg_data[BANK_BITS-1:0];
                        saved_reg <= cfg_data[BANK_BITS-1:0];
                    end
                    REG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[TICKS_WIDTH-1:0];
                    REG_RELEASE_TICKS: release_ticks_reg <= cfg_data[TICKS_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
